// ===== rtl/pbp_pkg.sv =====
`default_nettype none
package pbp_pkg;

    localparam int SLOTS     = 16;
    localparam int FILE_BITS = 8;
    localparam int PAGE_BITS = 24;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int LINK_W    = $clog2(SLOTS + 1);
    localparam int MAX_REC   = 16;
    localparam int REC_IW    = $clog2(MAX_REC);
    localparam int QDEPTH    = 2;
    localparam logic [7:0] PIN_MAX = 8'hFF;

    typedef enum logic [2:0] {
        KIND_FETCH   = 3'd0,
        KIND_ACQUIRE = 3'd1,
        KIND_UNPIN   = 3'd2,
        KIND_DIRTY   = 3'd3,
        KIND_FLUSH   = 3'd4,
        KIND_CLEAR   = 3'd5,
        KIND_WB      = 3'd6,
        KIND_NONE    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_PINNED  = 3'd2,
        ST_NOTRES  = 3'd3,
        ST_NOTPIN  = 3'd4,
        ST_NOFREE  = 3'd5,
        ST_PINFL   = 3'd6,
        ST_OVF     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        IO_NONE  = 2'd0,
        IO_READ  = 2'd1,
        IO_WRITE = 2'd2
    } io_t;

    typedef enum logic [3:0] {
        B_IDLE, B_LOOK, B_HIT, B_MISS, B_VICT, B_UNLINK, B_FRONT,
        B_CLAIM, B_WALK, B_FREE, B_OUT
    } bstate_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [FILE_BITS-1:0] file_id;
        logic [PAGE_BITS-1:0] page_number;
        logic                 allow_repin;
        logic                 all_pages;
    } in_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [3:0]           slot;
        logic [1:0]           io_kind;
        logic [FILE_BITS-1:0] io_file;
        logic [PAGE_BITS-1:0] io_page;
        logic                 last;
        logic [31:0]          pages_read;
        logic [31:0]          pages_written;
    } out_t;

    typedef struct packed {
        op_t                  op;
        logic [FILE_BITS-1:0] file_id;
        logic [PAGE_BITS-1:0] page_number;
        logic                 repin;
        logic                 all_pages;
    } req_t;

    typedef struct packed {
        io_t                  io;
        logic [FILE_BITS-1:0] file_id;
        logic [PAGE_BITS-1:0] page_number;
        logic [31:0]          rd;
        logic [31:0]          wr;
    } rec_t;

endpackage
`default_nettype wire

// ===== rtl/pbp_front.sv =====
`default_nettype none
module pbp_front (
    input  wire logic          start,
    input  wire pbp_pkg::in_t  request,
    input  wire logic          q_full,
    output logic               push,
    output pbp_pkg::req_t      push_data
);
    import pbp_pkg::*;

    // Decode the request kind into an operation for the back end.
    always_comb
    begin
        push                  = start && !q_full;
        push_data.file_id     = request.file_id;
        push_data.page_number = request.page_number;
        push_data.repin       = request.allow_repin;
        push_data.all_pages   = request.all_pages;
        unique case (request.kind)
            3'd0:    push_data.op = KIND_FETCH;
            3'd1:    push_data.op = KIND_ACQUIRE;
            3'd2:    push_data.op = KIND_UNPIN;
            3'd3:    push_data.op = KIND_DIRTY;
            3'd4:    push_data.op = KIND_FLUSH;
            3'd5:    push_data.op = KIND_CLEAR;
            3'd6:    push_data.op = KIND_WB;
            default: push_data.op = KIND_NONE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/pbp_queue.sv =====
`default_nettype none
module pbp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pbp_pkg::req_t  push_data,
    input  wire logic           pop,
    output logic                full,
    output logic                q_valid,
    output pbp_pkg::req_t       q_data
);
    import pbp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    req_t            mem_reg [QDEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [PW:0]     cnt_reg;

    assign full    = (cnt_reg == (PW + 1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW + 1)'(push) - (PW + 1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pbp_back.sv =====
`default_nettype none
module pbp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire pbp_pkg::req_t  q_data,
    output logic                pop,
    output logic                strobe,
    output pbp_pkg::out_t       result
);
    import pbp_pkg::*;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    bstate_t                state_reg, state_next;
    req_t                   r_reg, r_next;
    status_t                status_reg, status_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SLOT_W-1:0]      s_reg, s_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [LINK_W-1:0]      cur_reg, cur_next;
    logic [LINK_W-1:0]      nx_reg, nx_next;
    logic                   claim_reg, claim_next;
    logic [REC_IW:0]        cnt_reg, cnt_next;
    logic [REC_IW-1:0]      oidx_reg, oidx_next;
    logic [31:0]            rd_reg, rd_next;
    logic [31:0]            wr_reg, wr_next;

    logic                   valid_reg [SLOTS];
    logic                   valid_next [SLOTS];
    logic                   dirty_reg [SLOTS];
    logic                   dirty_next [SLOTS];
    logic [7:0]             pins_reg [SLOTS];
    logic [7:0]             pins_next [SLOTS];
    logic [LINK_W-1:0]      onext_reg [SLOTS];
    logic [LINK_W-1:0]      onext_next [SLOTS];
    logic [LINK_W-1:0]      oprev_reg [SLOTS];
    logic [LINK_W-1:0]      oprev_next [SLOTS];
    logic [LINK_W-1:0]      head_reg, head_next;
    logic [LINK_W-1:0]      tail_reg, tail_next;
    logic [LINK_W-1:0]      ftop_reg, ftop_next;
    logic [FILE_BITS-1:0]   efile_reg [SLOTS];
    logic [PAGE_BITS-1:0]   epage_reg [SLOTS];
    rec_t                   rec_reg [MAX_REC];

    logic                   claim_wr;
    logic                   emit_en;
    io_t                    emit_io;
    logic [FILE_BITS-1:0]   emit_file;
    logic [PAGE_BITS-1:0]   emit_page;
    logic [SLOT_W-1:0]      ci;
    logic                   cur_ok;
    logic [LINK_W-1:0]      nx;
    logic [LINK_W-1:0]      pv;
    logic [LINK_W-1:0]      s_link;

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        s_next      = s_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        nx_next     = nx_reg;
        claim_next  = claim_reg;
        cnt_next    = cnt_reg;
        oidx_next   = oidx_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        pins_next   = pins_reg;
        onext_next  = onext_reg;
        oprev_next  = oprev_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        ftop_next   = ftop_reg;
        pop         = 1'b0;
        claim_wr    = 1'b0;
        emit_en     = 1'b0;
        emit_io     = IO_WRITE;
        emit_file   = '0;
        emit_page   = '0;
        ci          = cur_reg[SLOT_W-1:0];
        cur_ok      = (cur_reg < NIL);
        s_link      = LINK_W'(s_reg);
        nx          = onext_reg[s_reg];
        pv          = oprev_reg[s_reg];

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop         = 1'b1;
                    r_next      = q_data;
                    status_next = ST_OK;
                    slot_next   = '0;
                    cnt_next    = '0;
                    oidx_next   = '0;
                    claim_next  = 1'b0;
                    idx_next    = '0;
                    cur_next    = head_reg;
                    case (q_data.op) inside
                        KIND_FETCH, KIND_ACQUIRE, KIND_UNPIN, KIND_DIRTY:
                            state_next = B_LOOK;
                        KIND_FLUSH, KIND_CLEAR, KIND_WB:
                            state_next = B_WALK;
                        default:
                            state_next = B_OUT;
                    endcase
                end
            end
            B_LOOK:
            begin
                if (valid_reg[idx_reg] && efile_reg[idx_reg] == r_reg.file_id
                    && epage_reg[idx_reg] == r_reg.page_number)
                begin
                    s_next     = idx_reg;
                    state_next = B_HIT;
                end
                else if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = B_MISS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_HIT:
            begin
                slot_next  = s_reg;
                state_next = B_OUT;
                case (r_reg.op)
                    KIND_ACQUIRE:
                        status_next = ST_EXISTS;
                    KIND_FETCH:
                    begin
                        if (pins_reg[s_reg] == 8'd1 && !r_reg.repin)
                        begin
                            status_next = ST_PINNED;
                        end
                        else
                        begin
                            if (pins_reg[s_reg] == PIN_MAX)
                            begin
                                status_next = ST_OVF;
                            end
                            else
                            begin
                                pins_next[s_reg] = pins_reg[s_reg] + 8'd1;
                            end
                            state_next = B_UNLINK;
                        end
                    end
                    KIND_UNPIN:
                    begin
                        if (pins_reg[s_reg] == 8'd0)
                        begin
                            status_next = ST_NOTPIN;
                        end
                        else
                        begin
                            pins_next[s_reg] = pins_reg[s_reg] - 8'd1;
                            if (pins_reg[s_reg] == 8'd1)
                            begin
                                state_next = B_UNLINK;
                            end
                        end
                    end
                    KIND_DIRTY:
                    begin
                        if (pins_reg[s_reg] == 8'd0)
                        begin
                            status_next = ST_NOTPIN;
                        end
                        else
                        begin
                            dirty_next[s_reg] = 1'b1;
                            state_next        = B_UNLINK;
                        end
                    end
                    default:
                        state_next = B_OUT;
                endcase
            end
            B_MISS:
            begin
                if (r_reg.op == KIND_UNPIN || r_reg.op == KIND_DIRTY)
                begin
                    status_next = ST_NOTRES;
                    state_next  = B_OUT;
                end
                else if (ftop_reg < NIL)
                begin
                    s_next     = ftop_reg[SLOT_W-1:0];
                    ftop_next  = onext_reg[ftop_reg[SLOT_W-1:0]];
                    claim_next = 1'b1;
                    state_next = B_FRONT;
                end
                else
                begin
                    cur_next   = tail_reg;
                    state_next = B_VICT;
                end
            end
            B_VICT:
            begin
                if (!cur_ok)
                begin
                    status_next = ST_NOFREE;
                    state_next  = B_OUT;
                end
                else if (pins_reg[ci] == 8'd0)
                begin
                    s_next     = ci;
                    claim_next = 1'b1;
                    if (dirty_reg[ci])
                    begin
                        emit_en        = 1'b1;
                        emit_io        = IO_WRITE;
                        emit_file      = efile_reg[ci];
                        emit_page      = epage_reg[ci];
                        dirty_next[ci] = 1'b0;
                    end
                    valid_next[ci] = 1'b0;
                    state_next     = B_UNLINK;
                end
                else
                begin
                    cur_next = oprev_reg[ci];
                end
            end
            B_UNLINK:
            begin
                if (head_reg == s_link)
                begin
                    head_next = nx;
                end
                if (tail_reg == s_link)
                begin
                    tail_next = pv;
                end
                if (nx < NIL)
                begin
                    oprev_next[nx[SLOT_W-1:0]] = pv;
                end
                if (pv < NIL)
                begin
                    onext_next[pv[SLOT_W-1:0]] = nx;
                end
                onext_next[s_reg] = NIL;
                oprev_next[s_reg] = NIL;
                state_next        = B_FRONT;
            end
            B_FRONT:
            begin
                onext_next[s_reg] = head_reg;
                oprev_next[s_reg] = NIL;
                if (head_reg < NIL)
                begin
                    oprev_next[head_reg[SLOT_W-1:0]] = s_link;
                end
                head_next = s_link;
                if (tail_reg >= NIL)
                begin
                    tail_next = s_link;
                end
                state_next = claim_reg ? B_CLAIM : B_OUT;
            end
            B_CLAIM:
            begin
                claim_wr          = 1'b1;
                valid_next[s_reg] = 1'b1;
                dirty_next[s_reg] = 1'b0;
                pins_next[s_reg]  = 8'd1;
                slot_next         = s_reg;
                if (r_reg.op == KIND_FETCH)
                begin
                    emit_en   = 1'b1;
                    emit_io   = IO_READ;
                    emit_file = r_reg.file_id;
                    emit_page = r_reg.page_number;
                end
                state_next = B_OUT;
            end
            B_WALK:
            begin
                cur_next = onext_reg[ci];
                if (!cur_ok)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    case (r_reg.op)
                        KIND_FLUSH:
                        begin
                            if (efile_reg[ci] == r_reg.file_id)
                            begin
                                if (pins_reg[ci] != 8'd0)
                                begin
                                    status_next = ST_PINFL;
                                    slot_next   = ci;
                                    state_next  = B_OUT;
                                end
                                else
                                begin
                                    if (dirty_reg[ci])
                                    begin
                                        emit_en        = 1'b1;
                                        emit_file      = efile_reg[ci];
                                        emit_page      = epage_reg[ci];
                                        dirty_next[ci] = 1'b0;
                                    end
                                    valid_next[ci] = 1'b0;
                                    s_next         = ci;
                                    nx_next        = onext_reg[ci];
                                    state_next     = B_FREE;
                                end
                            end
                        end
                        KIND_CLEAR:
                        begin
                            if (pins_reg[ci] == 8'd0)
                            begin
                                valid_next[ci] = 1'b0;
                                s_next         = ci;
                                nx_next        = onext_reg[ci];
                                state_next     = B_FREE;
                            end
                        end
                        default:
                        begin
                            if (efile_reg[ci] == r_reg.file_id && dirty_reg[ci]
                                && (r_reg.all_pages
                                    || epage_reg[ci] == r_reg.page_number))
                            begin
                                emit_en        = 1'b1;
                                emit_file      = efile_reg[ci];
                                emit_page      = epage_reg[ci];
                                dirty_next[ci] = 1'b0;
                            end
                        end
                    endcase
                end
            end
            B_FREE:
            begin
                // Unlink the frame and push it on the free stack.
                if (head_reg == s_link)
                begin
                    head_next = nx;
                end
                if (tail_reg == s_link)
                begin
                    tail_next = pv;
                end
                if (nx < NIL)
                begin
                    oprev_next[nx[SLOT_W-1:0]] = pv;
                end
                if (pv < NIL)
                begin
                    onext_next[pv[SLOT_W-1:0]] = nx;
                end
                onext_next[s_reg] = ftop_reg;
                oprev_next[s_reg] = NIL;
                ftop_next         = s_link;
                cur_next          = nx_reg;
                state_next        = B_WALK;
            end
            B_OUT:
            begin
                if (cnt_reg == '0
                    || (REC_IW + 1)'(oidx_reg) == cnt_reg - 1'b1)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    oidx_next = oidx_reg + 1'b1;
                end
            end
            default:
                state_next = B_IDLE;
        endcase

        rd_next = rd_reg;
        wr_next = wr_reg;
        if (emit_en)
        begin
            if (emit_io == IO_READ)
            begin
                rd_next = rd_reg + 32'd1;
            end
            else
            begin
                wr_next = wr_reg + 32'd1;
            end
            if (cnt_reg < (REC_IW + 1)'(MAX_REC))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        strobe        = (state_reg == B_OUT);
        result.status = status_reg;
        result.slot   = 4'(slot_reg);
        if (cnt_reg == '0)
        begin
            result.io_kind       = IO_NONE;
            result.io_file       = '0;
            result.io_page       = '0;
            result.last          = 1'b1;
            result.pages_read    = rd_reg;
            result.pages_written = wr_reg;
        end
        else
        begin
            result.io_kind       = rec_reg[oidx_reg].io;
            result.io_file       = rec_reg[oidx_reg].file_id;
            result.io_page       = rec_reg[oidx_reg].page_number;
            result.last          = ((REC_IW + 1)'(oidx_reg) == cnt_reg - 1'b1);
            result.pages_read    = rec_reg[oidx_reg].rd;
            result.pages_written = rec_reg[oidx_reg].wr;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        s_reg    <= s_next;
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        nx_reg   <= nx_next;
        slot_reg <= slot_next;
        if (claim_wr)
        begin
            efile_reg[s_reg] <= r_reg.file_id;
            epage_reg[s_reg] <= r_reg.page_number;
        end
        if (emit_en && cnt_reg < (REC_IW + 1)'(MAX_REC))
        begin
            rec_reg[cnt_reg[REC_IW-1:0]] <= '{io: emit_io, file_id: emit_file,
                page_number: emit_page, rd: rd_next, wr: wr_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            status_reg <= ST_OK;
            claim_reg  <= 1'b0;
            cnt_reg    <= '0;
            oidx_reg   <= '0;
            rd_reg     <= '0;
            wr_reg     <= '0;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            ftop_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                pins_reg[i]  <= '0;
                onext_reg[i] <= LINK_W'(i + 1);
                oprev_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            claim_reg  <= claim_next;
            cnt_reg    <= cnt_next;
            oidx_reg   <= oidx_next;
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            ftop_reg   <= ftop_next;
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            pins_reg   <= pins_next;
            onext_reg  <= onext_next;
            oprev_reg  <= oprev_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/page_buffer_pool_lru_pinning.sv =====
// The lookup scan walks up to SLOTS frames one per cycle; a flush passes each freed frame
// through a walk step and then a free step.
// Throughput: one request at a time in the back end; results leave one per cycle.
// A two-entry request queue takes new transfers while the back end is working.
// Reset: asynchronous, active low; all frames free, counters zero. The receiver cannot stall.
`default_nettype none
module page_buffer_pool_lru_pinning (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire pbp_pkg::in_t  request,
    output logic               busy,
    output logic               strobe,
    output pbp_pkg::out_t      result
);
    import pbp_pkg::*;

    // The front end decodes each request and places it in the queue.
    // The back end owns all frame state: it performs the lookup scan,
    // frame taking, list updates and list walks, and records the I/O
    // transfers of a request so that they can carry the final status.
    logic  push;
    req_t  push_data;
    logic  q_full;
    logic  q_valid;
    req_t  q_data;
    logic  pop;

    assign busy = q_full;

    pbp_front u_front (
        .start     (start),
        .request   (request),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    pbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // Results of one request appear on consecutive cycles, last one marked.
    pbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .strobe  (strobe),
        .result  (result)
    );
endmodule
`default_nettype wire

// ===== rtl/pbp_checker.sv =====
`default_nettype none
module pbp_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          strobe,
    input  wire pbp_pkg::out_t result
);
    import pbp_pkg::*;

    a_quiet_io: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.io_kind == IO_NONE |-> result.io_file == '0
            && result.io_page == '0 && result.last)
        else $error("result without I/O carries a page or is not last");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe && $stable(result.status)
            && $stable(result.slot))
        else $error("results of one request are not back to back");

    a_reads_mono: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last && result.io_kind == IO_READ |=>
            result.pages_read != $past(result.pages_read))
        else $error("read total did not advance");

    a_no_out_after_reset: assert property (@(posedge clk)
        !rst_n |=> !strobe)
        else $error("result strobe right after reset");
endmodule

bind page_buffer_pool_lru_pinning pbp_checker u_pbp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);
`default_nettype wire

// ===== dv/tb_page_buffer_pool_lru_pinning.sv =====
`default_nettype none
module tb_page_buffer_pool_lru_pinning;
    timeunit 1ns;
    timeprecision 1ps;
    import pbp_pkg::*;

    localparam int NIL = SLOTS;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    in_t  request;
    logic busy;
    logic strobe;
    out_t result;

    page_buffer_pool_lru_pinning u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    // The clock runs with a 12 ns period, high and low for half each.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow copy of the frame pool. Files and pages of frames that were
    // never claimed are only looked at behind a valid check or through
    // the LRU list of claimed frames, so their initial zeros never matter.
    logic                 pool_valid [SLOTS];
    logic [FILE_BITS-1:0] pool_file  [SLOTS];
    logic [PAGE_BITS-1:0] pool_page  [SLOTS];
    logic                 pool_dirty [SLOTS];
    logic [7:0]           pool_pins  [SLOTS];
    int                   lru_next   [SLOTS];
    int                   lru_prev   [SLOTS];
    int                   lru_head;
    int                   lru_tail;
    int                   free_head;
    logic [31:0]          reads_done;
    logic [31:0]          writes_done;

    // Results still owed by the block, oldest first.
    out_t pending_results[$];
    // I/O of the request now being predicted, in issue order.
    out_t io_trail[$];

    int  error_count;
    int  cycle_count;
    bit  idle_enable;

    // Pages are drawn from a small set so that hits, evictions and flushes
    // happen often; the file and page lists include the extreme values.
    logic [FILE_BITS-1:0] file_pool [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};
    logic [PAGE_BITS-1:0] page_pool [6] = '{24'h000000, 24'h000001, 24'h000002,
                                            24'h5A5A5A, 24'hA5A5A5, 24'hFFFFFF};

    function automatic void pool_reset();
        for (int s = 0; s < SLOTS; s++)
        begin
            pool_valid[s] = 1'b0;
            pool_file[s]  = '0;
            pool_page[s]  = '0;
            pool_dirty[s] = 1'b0;
            pool_pins[s]  = 8'd0;
            lru_next[s]   = s + 1;
            lru_prev[s]   = NIL;
        end
        lru_head    = NIL;
        lru_tail    = NIL;
        free_head   = 0;
        reads_done  = '0;
        writes_done = '0;
    endfunction

    function automatic void log_io(io_t io, logic [FILE_BITS-1:0] f, logic [PAGE_BITS-1:0] p);
        out_t r;
        if (io == IO_READ)
            reads_done = reads_done + 32'd1;
        else
            writes_done = writes_done + 32'd1;
        if (io_trail.size() < MAX_REC)
        begin
            r = '0;
            r.io_kind       = io;
            r.io_file       = f;
            r.io_page       = p;
            r.pages_read    = reads_done;
            r.pages_written = writes_done;
            io_trail.push_back(r);
        end
    endfunction

    function automatic int find_frame(logic [FILE_BITS-1:0] f, logic [PAGE_BITS-1:0] p);
        for (int s = 0; s < SLOTS; s++)
            if (pool_valid[s] && pool_file[s] == f && pool_page[s] == p)
                return s;
        return NIL;
    endfunction

    function automatic void lru_remove(int s);
        int nx;
        int pv;
        nx = lru_next[s];
        pv = lru_prev[s];
        if (lru_head == s) lru_head = nx;
        if (lru_tail == s) lru_tail = pv;
        if (nx < SLOTS) lru_prev[nx] = pv;
        if (pv < SLOTS) lru_next[pv] = nx;
        lru_next[s] = NIL;
        lru_prev[s] = NIL;
    endfunction

    function automatic void lru_push_front(int s);
        lru_next[s] = lru_head;
        lru_prev[s] = NIL;
        if (lru_head < SLOTS) lru_prev[lru_head] = s;
        lru_head = s;
        if (lru_tail >= SLOTS) lru_tail = lru_head;
    endfunction

    function automatic void release_frame(int s);
        pool_valid[s] = 1'b0;
        lru_remove(s);
        lru_next[s] = free_head;
        free_head = s;
    endfunction

    // Takes a free frame, or else evicts the least recent unpinned one,
    // writing it back first when dirty. Returns NIL when all are pinned.
    function automatic int grab_frame();
        int s;
        if (free_head < SLOTS)
        begin
            s = free_head;
            free_head = lru_next[s];
            lru_push_front(s);
            return s;
        end
        s = lru_tail;
        for (int n = 0; n < SLOTS && s < SLOTS; n++)
        begin
            if (pool_pins[s] == 8'd0) break;
            s = lru_prev[s];
        end
        if (s >= SLOTS || pool_pins[s] != 8'd0) return NIL;
        if (pool_dirty[s])
        begin
            log_io(IO_WRITE, pool_file[s], pool_page[s]);
            pool_dirty[s] = 1'b0;
        end
        pool_valid[s] = 1'b0;
        lru_remove(s);
        lru_push_front(s);
        return s;
    endfunction

    // Applies one request to the shadow pool and queues the results it owes.
    function automatic void predict_request(in_t rq);
        status_t st;
        int      slot;
        int      s;
        int      nx;
        out_t    r;
        op_t     op;
        st   = ST_OK;
        slot = 0;
        op   = op_t'(rq.kind);
        io_trail.delete();
        case (op) inside
            KIND_FETCH, KIND_ACQUIRE:
            begin
                s = find_frame(rq.file_id, rq.page_number);
                if (s < SLOTS)
                begin
                    slot = s;
                    if (op == KIND_ACQUIRE)
                        st = ST_EXISTS;
                    else if (pool_pins[s] == 8'd1 && !rq.allow_repin)
                        st = ST_PINNED;
                    else
                    begin
                        if (pool_pins[s] == PIN_MAX)
                            st = ST_OVF;
                        else
                            pool_pins[s] = pool_pins[s] + 8'd1;
                        lru_remove(s);
                        lru_push_front(s);
                    end
                end
                else
                begin
                    s = grab_frame();
                    if (s >= SLOTS)
                        st = ST_NOFREE;
                    else
                    begin
                        slot = s;
                        pool_valid[s] = 1'b1;
                        pool_file[s]  = rq.file_id;
                        pool_page[s]  = rq.page_number;
                        pool_dirty[s] = 1'b0;
                        pool_pins[s]  = 8'd1;
                        if (op == KIND_FETCH)
                            log_io(IO_READ, rq.file_id, rq.page_number);
                    end
                end
            end
            KIND_UNPIN, KIND_DIRTY:
            begin
                s = find_frame(rq.file_id, rq.page_number);
                if (s >= SLOTS)
                    st = ST_NOTRES;
                else
                begin
                    slot = s;
                    if (pool_pins[s] == 8'd0)
                        st = ST_NOTPIN;
                    else if (op == KIND_UNPIN)
                    begin
                        pool_pins[s] = pool_pins[s] - 8'd1;
                        if (pool_pins[s] == 8'd0)
                        begin
                            lru_remove(s);
                            lru_push_front(s);
                        end
                    end
                    else
                    begin
                        pool_dirty[s] = 1'b1;
                        lru_remove(s);
                        lru_push_front(s);
                    end
                end
            end
            KIND_FLUSH:
            begin
                s = lru_head;
                for (int n = 0; n < SLOTS && s < SLOTS; n++)
                begin
                    nx = lru_next[s];
                    if (pool_file[s] == rq.file_id)
                    begin
                        if (pool_pins[s] != 8'd0)
                        begin
                            st = ST_PINFL;
                            slot = s;
                            break;
                        end
                        if (pool_dirty[s])
                        begin
                            log_io(IO_WRITE, pool_file[s], pool_page[s]);
                            pool_dirty[s] = 1'b0;
                        end
                        release_frame(s);
                    end
                    s = nx;
                end
            end
            KIND_CLEAR:
            begin
                s = lru_head;
                for (int n = 0; n < SLOTS && s < SLOTS; n++)
                begin
                    nx = lru_next[s];
                    if (pool_pins[s] == 8'd0) release_frame(s);
                    s = nx;
                end
            end
            KIND_WB:
            begin
                s = lru_head;
                for (int n = 0; n < SLOTS && s < SLOTS; n++)
                begin
                    if (pool_file[s] == rq.file_id && pool_dirty[s] &&
                        (rq.all_pages || pool_page[s] == rq.page_number))
                    begin
                        log_io(IO_WRITE, pool_file[s], pool_page[s]);
                        pool_dirty[s] = 1'b0;
                    end
                    s = lru_next[s];
                end
            end
            default:
            begin
            end
        endcase
        if (io_trail.size() == 0)
        begin
            r = '0;
            r.io_kind       = IO_NONE;
            r.pages_read    = reads_done;
            r.pages_written = writes_done;
            io_trail.push_back(r);
        end
        foreach (io_trail[k])
        begin
            r        = io_trail[k];
            r.status = st;
            r.slot   = slot[3:0];
            r.last   = (k == io_trail.size() - 1);
            pending_results.push_back(r);
        end
    endfunction

    // Sends one request and waits until the block takes the transfer.
    // The prediction is made when the transfer is accepted. Start stays
    // high afterwards so that the next request can follow right away; it
    // drops during an idle gap and while the sender waits for results.
    task automatic send_request(in_t rq);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_request(rq);
    endtask

    function automatic in_t make_request(op_t op, int fi, int pi, bit repin, bit all);
        in_t rq;
        rq.kind        = op;
        rq.file_id     = file_pool[fi];
        rq.page_number = page_pool[pi];
        rq.allow_repin = repin;
        rq.all_pages   = all;
        return rq;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Result checker. Outputs are sampled at the rising edge, where the block
    // updates them with nonblocking assignments, so values are stable here.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: %p", result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    error_count++;
                end
                if (result.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, result.slot);
                    error_count++;
                end
                if (result.io_kind !== want.io_kind)
                begin
                    $error("io_kind: expected %0d, got %0d", want.io_kind, result.io_kind);
                    error_count++;
                end
                if (result.io_file !== want.io_file)
                begin
                    $error("io_file: expected %0h, got %0h", want.io_file, result.io_file);
                    error_count++;
                end
                if (result.io_page !== want.io_page)
                begin
                    $error("io_page: expected %0h, got %0h", want.io_page, result.io_page);
                    error_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    error_count++;
                end
                if (result.pages_read !== want.pages_read)
                begin
                    $error("pages_read: expected %0d, got %0d",
                           want.pages_read, result.pages_read);
                    error_count++;
                end
                if (result.pages_written !== want.pages_written)
                begin
                    $error("pages_written: expected %0d, got %0d",
                           want.pages_written, result.pages_written);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Every operation, the undefined kind and the extreme field values,
    // starting from an empty pool.
    task automatic test_basic_ops();
        in_t rq;
        send_request(make_request(KIND_FETCH, 0, 0, 1'b0, 1'b0));
        send_request(make_request(KIND_FETCH, 0, 0, 1'b0, 1'b0));
        send_request(make_request(KIND_FETCH, 0, 0, 1'b1, 1'b0));
        send_request(make_request(KIND_ACQUIRE, 3, 5, 1'b0, 1'b0));
        send_request(make_request(KIND_ACQUIRE, 3, 5, 1'b1, 1'b1));
        send_request(make_request(KIND_DIRTY, 3, 5, 1'b0, 1'b0));
        send_request(make_request(KIND_DIRTY, 2, 3, 1'b0, 1'b0));
        send_request(make_request(KIND_UNPIN, 3, 5, 1'b0, 1'b0));
        send_request(make_request(KIND_UNPIN, 3, 5, 1'b0, 1'b0));
        send_request(make_request(KIND_DIRTY, 3, 5, 1'b0, 1'b0));
        send_request(make_request(KIND_UNPIN, 1, 1, 1'b0, 1'b0));
        send_request(make_request(KIND_WB, 0, 0, 1'b0, 1'b1));
        send_request(make_request(KIND_WB, 3, 4, 1'b0, 1'b0));
        send_request(make_request(KIND_FLUSH, 0, 0, 1'b0, 1'b0));
        send_request(make_request(KIND_FLUSH, 3, 5, 1'b0, 1'b0));
        send_request(make_request(KIND_CLEAR, 0, 0, 1'b0, 1'b0));
        rq = make_request(KIND_NONE, 3, 5, 1'b1, 1'b1);
        send_request(rq);
        send_request(make_request(KIND_CLEAR, 0, 0, 1'b0, 1'b0));
        wait_drained();
    endtask

    // Fills every frame with pinned pages so that a further fetch finds no
    // frame, then frees one dirty frame so the next miss evicts it with a
    // write-back, then flushes a file that still has a pinned page.
    task automatic test_eviction();
        in_t rq;
        for (int s = 0; s < SLOTS; s++)
        begin
            rq = make_request(KIND_FETCH, 1, 0, 1'b0, 1'b0);
            rq.page_number = PAGE_BITS'(24'h000100 + s);
            send_request(rq);
        end
        rq = make_request(KIND_FETCH, 2, 2, 1'b0, 1'b0);
        send_request(rq);
        rq = make_request(KIND_DIRTY, 1, 0, 1'b0, 1'b0);
        rq.page_number = 24'h000103;
        send_request(rq);
        rq.kind = KIND_UNPIN;
        send_request(rq);
        send_request(make_request(KIND_ACQUIRE, 2, 2, 1'b0, 1'b0));
        send_request(make_request(KIND_FLUSH, 1, 0, 1'b0, 1'b0));
        wait_drained();
        // Release everything so later phases start from a clean pool.
        for (int s = 0; s < SLOTS; s++)
        begin
            if (pool_valid[s])
            begin
                rq.kind        = KIND_UNPIN;
                rq.file_id     = pool_file[s];
                rq.page_number = pool_page[s];
                while (pool_pins[s] != 8'd0) send_request(rq);
            end
        end
        send_request(make_request(KIND_CLEAR, 0, 0, 1'b0, 1'b0));
        wait_drained();
    endtask

    // Pins one page 256 times so the count saturates and reports overflow.
    // The page stays pinned and takes part in the random phase.
    task automatic test_pin_overflow();
        in_t rq;
        bit  saved;
        saved = idle_enable;
        idle_enable = 1'b0;
        rq = make_request(KIND_FETCH, 2, 4, 1'b1, 1'b0);
        for (int n = 0; n < 256; n++) send_request(rq);
        idle_enable = saved;
        wait_drained();
    endtask

    // Random requests, weighted toward fetch, unpin and mark dirty on a small
    // page set so that resident hits, evictions and dirty write-backs dominate.
    task automatic test_random(int count);
        in_t rq;
        int  pick;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                // The sender holds off until every result has come back.
                wait_drained();
            end
            if (n >= count - count / 5)
                idle_enable = 1'b0;
            pick = $urandom_range(0, 99);
            rq = make_request(KIND_FETCH, $urandom_range(0, 3), $urandom_range(0, 5),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (pick < 35)
                rq.kind = KIND_FETCH;
            else if (pick < 45)
                rq.kind = KIND_ACQUIRE;
            else if (pick < 65)
                rq.kind = KIND_UNPIN;
            else if (pick < 80)
                rq.kind = KIND_DIRTY;
            else if (pick < 86)
                rq.kind = KIND_WB;
            else if (pick < 91)
                rq.kind = KIND_FLUSH;
            else if (pick < 95)
                rq.kind = KIND_CLEAR;
            else if (pick < 97)
                rq.kind = KIND_NONE;
            else
            begin
                rq.kind        = 3'($urandom_range(0, 7));
                rq.file_id     = FILE_BITS'($urandom);
                rq.page_number = PAGE_BITS'($urandom);
            end
            send_request(rq);
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        pool_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_eviction();
        test_pin_overflow();
        test_random(40);

        wait_drained();
        repeat (3 * SLOTS + 20) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
